>>> src/svge_pkg.sv
// ----------------------------------------------------------------------------
// svge_pkg
// Shared types and constants of the state vector gate engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svge_pkg;

  localparam int QSEL_W = 4;
  localparam int QCNT_W = 5;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 10;
  localparam int PROB_W = 31;

  localparam int COEF_W    = 31;
  localparam int COEF_FRAC = 30;
  localparam logic [COEF_W-1:0] INV_SQRT2_Q30 = 31'd759250125;
  localparam logic [COEF_W-1:0] UNIT_Q30      = 31'd1073741824;

  localparam logic [QSEL_W-1:0] QUBITS_RESET = 4'd10;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_HADAMARD = 2'd0,
    OP_CNOT     = 2'd1,
    OP_PROB     = 2'd2,
    OP_GROUND   = 2'd3
  } svge_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_GATE  = 3'd2,
    ST_DRAIN = 3'd3,
    ST_PROB  = 3'd4,
    ST_DONE  = 3'd5
  } svge_state_e;

  typedef struct packed {
    logic vld;
    logic is_had;
    logic swap;
  } svge_pair_t;

endpackage

`default_nettype wire

>>> src/svge_amp_mem.sv
// ----------------------------------------------------------------------------
// svge_amp_mem
// Amplitude memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svge_amp_mem #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 36
) (
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] rd_addr_a_i,
  input  logic [ADDR_W-1:0] rd_addr_b_i,
  output logic [DATA_W-1:0] rd_data_a_o,
  output logic [DATA_W-1:0] rd_data_b_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_a_q;
  logic [DATA_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[rd_addr_a_i];
    rd_b_q <= mem[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

`default_nettype wire

>>> src/svge_butterfly.sv
// ----------------------------------------------------------------------------
// svge_butterfly
// Pipelined pair unit: Hadamard butterfly or CNOT swap on one amplitude pair,
// writing both results back through one write port, low address first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svge_butterfly #(
  parameter int AMP_BITS = 18,
  parameter int ADDR_W   = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  svge_pkg::svge_pair_t    pair_i,
  input  logic [ADDR_W-1:0]       addr_lo_i,
  input  logic [ADDR_W-1:0]       addr_hi_i,
  input  logic [2*AMP_BITS-1:0]   rd_lo_i,
  input  logic [2*AMP_BITS-1:0]   rd_hi_i,
  output logic                    wr_en_o,
  output logic [ADDR_W-1:0]       wr_addr_o,
  output logic [2*AMP_BITS-1:0]   wr_data_o,
  output logic                    busy_o
);

  import svge_pkg::*;

  localparam int DW  = 2 * AMP_BITS;
  localparam int X_W = AMP_BITS + 1;
  localparam int P_W = X_W + COEF_W + 1;
  localparam int R_W = P_W - COEF_FRAC;
  localparam logic signed [P_W-1:0] RND = P_W'(1) << (COEF_FRAC - 1);
  localparam logic [AMP_BITS-1:0] AMP_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
  localparam logic [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};

  function automatic logic [AMP_BITS-1:0] round_sat(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] s;
    logic [R_W-1:0] r;
    logic [R_W-AMP_BITS:0] top;
    logic [AMP_BITS-1:0] res;
    s = p + RND;
    r = s[P_W-1:COEF_FRAC];
    top = r[R_W-1:AMP_BITS-1];
    if ((&top) || !(|top)) begin
      res = r[AMP_BITS-1:0];
    end else if (r[R_W-1]) begin
      res = AMP_MIN;
    end else begin
      res = AMP_MAX;
    end
    return res;
  endfunction

  svge_pair_t pair1_q, pair2_q, pair3_q;
  logic vld4_q, vld5_q;
  logic [ADDR_W-1:0] lo1_q, hi1_q, lo2_q, hi2_q, lo3_q, hi3_q, lo4_q, hi4_q;

  logic signed [X_W-1:0] are, aim, bre, bim;
  logic signed [X_W-1:0] x0re_d, x0im_d, x1re_d, x1im_d;
  logic signed [X_W-1:0] x0re_q, x0im_q, x1re_q, x1im_q;
  logic signed [COEF_W:0] coef_s;
  logic signed [P_W-1:0] p0re_d, p0im_d, p1re_d, p1im_d;
  logic signed [P_W-1:0] p0re_q, p0im_q, p1re_q, p1im_q;
  logic [DW-1:0] w0_q, w1_q;

  assign are = {rd_lo_i[DW-1], rd_lo_i[DW-1:AMP_BITS]};
  assign aim = {rd_lo_i[AMP_BITS-1], rd_lo_i[AMP_BITS-1:0]};
  assign bre = {rd_hi_i[DW-1], rd_hi_i[DW-1:AMP_BITS]};
  assign bim = {rd_hi_i[AMP_BITS-1], rd_hi_i[AMP_BITS-1:0]};

  always_comb begin
    if (pair1_q.is_had) begin
      x0re_d = are + bre;
      x0im_d = aim + bim;
      x1re_d = are - bre;
      x1im_d = aim - bim;
    end else if (pair1_q.swap) begin
      x0re_d = bre;
      x0im_d = bim;
      x1re_d = are;
      x1im_d = aim;
    end else begin
      x0re_d = are;
      x0im_d = aim;
      x1re_d = bre;
      x1im_d = bim;
    end
  end

  // A swap goes through the multiplier at unit gain, so rounding leaves it exact.
  assign coef_s = {1'b0, (pair2_q.is_had ? INV_SQRT2_Q30 : UNIT_Q30)};
  assign p0re_d = x0re_q * coef_s;
  assign p0im_d = x0im_q * coef_s;
  assign p1re_d = x1re_q * coef_s;
  assign p1im_d = x1im_q * coef_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair1_q <= '0;
      pair2_q <= '0;
      pair3_q <= '0;
      vld4_q  <= 1'b0;
      vld5_q  <= 1'b0;
    end else begin
      pair1_q <= pair_i;
      pair2_q <= pair1_q;
      pair3_q <= pair2_q;
      vld4_q  <= pair3_q.vld;
      vld5_q  <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo1_q  <= addr_lo_i;
    hi1_q  <= addr_hi_i;
    lo2_q  <= lo1_q;
    hi2_q  <= hi1_q;
    lo3_q  <= lo2_q;
    hi3_q  <= hi2_q;
    lo4_q  <= lo3_q;
    hi4_q  <= hi3_q;
    x0re_q <= x0re_d;
    x0im_q <= x0im_d;
    x1re_q <= x1re_d;
    x1im_q <= x1im_d;
    p0re_q <= p0re_d;
    p0im_q <= p0im_d;
    p1re_q <= p1re_d;
    p1im_q <= p1im_d;
    w0_q   <= {round_sat(p0re_q), round_sat(p0im_q)};
    w1_q   <= {round_sat(p1re_q), round_sat(p1im_q)};
  end

  assign wr_en_o   = vld4_q | vld5_q;
  assign wr_addr_o = vld4_q ? lo4_q : hi4_q;
  assign wr_data_o = vld4_q ? w0_q : w1_q;
  assign busy_o    = pair1_q.vld | pair2_q.vld | pair3_q.vld | vld4_q | vld5_q;

endmodule

`default_nettype wire

>>> src/svge_prob.sv
// ----------------------------------------------------------------------------
// svge_prob
// Probability unit: squared magnitude of one amplitude, scaled to Q1.30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svge_prob #(
  parameter int AMP_BITS = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [2*AMP_BITS-1:0]       rd_i,
  output logic                        done_o,
  output logic [svge_pkg::PROB_W-1:0] prob_o
);

  import svge_pkg::*;

  localparam int SQ_W   = 2 * AMP_BITS - 1;
  localparam int SUM_W  = 2 * AMP_BITS;
  localparam int PSHIFT = 2 * AMP_BITS - 2 * COEF_FRAC + 26;
  localparam int LSH    = (PSHIFT < 0) ? -PSHIFT : 0;
  localparam int SC_W   = SUM_W + LSH;

  logic vld1_q, vld2_q, vld3_q;
  logic signed [AMP_BITS-1:0] re_v, im_v;
  logic signed [SUM_W-1:0] re_prod, im_prod;
  logic [SQ_W-1:0] re_sq_q, im_sq_q;
  logic [SUM_W-1:0] sum;
  logic [SC_W-1:0] scaled;
  logic [PROB_W-1:0] prob_d, prob_q;

  assign re_v    = rd_i[2*AMP_BITS-1:AMP_BITS];
  assign im_v    = rd_i[AMP_BITS-1:0];
  assign re_prod = re_v * re_v;
  assign im_prod = im_v * im_v;
  assign sum     = SUM_W'(re_sq_q) + SUM_W'(im_sq_q);

  generate
    if (PSHIFT > 0) begin : g_rshift
      localparam logic [SC_W-1:0] RND = SC_W'(1) << (PSHIFT - 1);
      assign scaled = (SC_W'(sum) + RND) >> PSHIFT;
    end else if (PSHIFT < 0) begin : g_lshift
      assign scaled = SC_W'(sum) << LSH;
    end else begin : g_keep
      assign scaled = SC_W'(sum);
    end
  endgenerate

  assign prob_d = (|scaled[SC_W-1:PROB_W]) ? '1 : scaled[PROB_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    re_sq_q <= re_prod[SQ_W-1:0];
    im_sq_q <= im_prod[SQ_W-1:0];
    prob_q  <= prob_d;
  end

  assign done_o = vld3_q;
  assign prob_o = prob_q;

endmodule

`default_nettype wire

>>> src/state_vector_gate_engine.sv
// ----------------------------------------------------------------------------
// state_vector_gate_engine
// Quantum state vector engine: Hadamard and CNOT gates, probability readout
// and ground-state reset over an amplitude memory.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Beat
//  cfg      | cfg_valid_i / cfg_ready_o  | qubits_in_use (always ready)
//  in       | in_valid_i / in_stall_o    | op, target_bit, control_bit, basis_index
//  out      | out_valid_o / out_stall_i  | status, probability
//
//  A gate issues the amplitude pairs in turn, its pace bounded by the
//  single write port of the amplitude memory.
//  A probability read passes through svge_prob; an invalid request goes straight to ST_DONE.
//  Reset and the ground-state op sweep all 2^MAX_QUBITS entries, one a cycle,
//  with the input stalled.
//  A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module state_vector_gate_engine #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_BITS   = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [svge_pkg::QSEL_W-1:0] cfg_qubits_in_use_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [svge_pkg::OP_W-1:0]   op_i,
  input  logic [svge_pkg::QSEL_W-1:0] target_bit_i,
  input  logic [svge_pkg::QSEL_W-1:0] control_bit_i,
  input  logic [svge_pkg::IDX_W-1:0]  basis_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [svge_pkg::PROB_W-1:0] probability_o
);

  import svge_pkg::*;

  localparam int AW = MAX_QUBITS;
  localparam int DW = 2 * AMP_BITS;
  localparam logic [DW-1:0] GROUND_AMP =
    {(AMP_BITS'(1) << (AMP_BITS - 2)), {AMP_BITS{1'b0}}};

  svge_state_e state_q, state_d;
  logic [QSEL_W-1:0] qubits_q;
  svge_op_e op_q, op_d, op_in;
  logic [QSEL_W-1:0] tgt_q, tgt_d, ctl_q, ctl_d;
  logic [AW-1:0] pair_cnt_q, pair_cnt_d, clr_cnt_q, clr_cnt_d;
  logic phase_q, phase_d;
  logic clr_reply_q, clr_reply_d;
  logic res_status_q, res_status_d;
  logic [PROB_W-1:0] res_prob_q, res_prob_d;
  logic out_valid_q, out_valid_d, out_status_q;
  logic [PROB_W-1:0] out_prob_q;
  logic out_load;

  logic [QCNT_W-1:0] n_act;
  logic tgt_bad, ctl_bad, idx_bad;
  logic [AW-1:0] tmask, cmask, low_mask, half, last_pair, lo_addr, hi_addr;
  logic [AW+IDX_W-1:0] idx_ext;

  logic [AW-1:0] rd_addr_a;
  logic [DW-1:0] rd_data_a, rd_data_b;
  logic mem_wr_en, bf_wr_en;
  logic [AW-1:0] mem_wr_addr, bf_wr_addr;
  logic [DW-1:0] mem_wr_data, bf_wr_data;
  svge_pair_t pair;
  logic bf_busy, prob_start, prob_done;
  logic [PROB_W-1:0] prob_val;

  always_comb begin
    if (qubits_q == '0) begin
      n_act = QCNT_W'(1);
    end else if ({1'b0, qubits_q} > QCNT_W'(MAX_QUBITS)) begin
      n_act = QCNT_W'(MAX_QUBITS);
    end else begin
      n_act = {1'b0, qubits_q};
    end
  end

  assign op_in   = svge_op_e'(op_i);
  assign tgt_bad = {1'b0, target_bit_i} >= n_act;
  assign ctl_bad = ({1'b0, control_bit_i} >= n_act) || (control_bit_i == target_bit_i);
  assign idx_bad = (basis_index_i >> n_act) != '0;
  assign idx_ext = {AW'(0), basis_index_i};

  assign tmask     = AW'(1) << tgt_q;
  assign cmask     = AW'(1) << ctl_q;
  assign low_mask  = tmask - AW'(1);
  assign half      = AW'(1) << (n_act - QCNT_W'(1));
  assign last_pair = half - AW'(1);
  assign lo_addr   = ((pair_cnt_q & ~low_mask) << 1) | (pair_cnt_q & low_mask);
  assign hi_addr   = lo_addr | tmask;

  assign pair.vld    = (state_q == ST_GATE) && !phase_q;
  assign pair.is_had = (op_q == OP_HADAMARD);
  assign pair.swap   = |(lo_addr & cmask);

  assign rd_addr_a  = (state_q == ST_IDLE) ? idx_ext[AW-1:0] : lo_addr;
  assign prob_start = (state_q == ST_IDLE) && in_valid_i && (op_in == OP_PROB) && !idx_bad;

  assign mem_wr_en   = (state_q == ST_CLEAR) | bf_wr_en;
  assign mem_wr_addr = (state_q == ST_CLEAR) ? clr_cnt_q : bf_wr_addr;
  assign mem_wr_data = (state_q != ST_CLEAR) ? bf_wr_data :
                       (clr_cnt_q == '0) ? GROUND_AMP : '0;

  svge_amp_mem #(
    .ADDR_W (AW),
    .DATA_W (DW)
  ) u_mem (
    .clk_i       (clk_i),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (hi_addr),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b),
    .wr_en_i     (mem_wr_en),
    .wr_addr_i   (mem_wr_addr),
    .wr_data_i   (mem_wr_data)
  );

  svge_butterfly #(
    .AMP_BITS (AMP_BITS),
    .ADDR_W   (AW)
  ) u_butterfly (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pair_i    (pair),
    .addr_lo_i (lo_addr),
    .addr_hi_i (hi_addr),
    .rd_lo_i   (rd_data_a),
    .rd_hi_i   (rd_data_b),
    .wr_en_o   (bf_wr_en),
    .wr_addr_o (bf_wr_addr),
    .wr_data_o (bf_wr_data),
    .busy_o    (bf_busy)
  );

  svge_prob #(
    .AMP_BITS (AMP_BITS)
  ) u_prob (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prob_start),
    .rd_i    (rd_data_a),
    .done_o  (prob_done),
    .prob_o  (prob_val)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    tgt_d        = tgt_q;
    ctl_d        = ctl_q;
    pair_cnt_d   = pair_cnt_q;
    clr_cnt_d    = clr_cnt_q;
    phase_d      = phase_q;
    clr_reply_d  = clr_reply_q;
    res_status_d = res_status_q;
    res_prob_d   = res_prob_q;
    out_load     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == '1) begin
          state_d     = clr_reply_q ? ST_DONE : ST_IDLE;
          clr_reply_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_in;
          tgt_d        = target_bit_i;
          ctl_d        = control_bit_i;
          res_status_d = STATUS_OK;
          res_prob_d   = '0;
          pair_cnt_d   = '0;
          phase_d      = 1'b0;
          case (op_in)
            OP_HADAMARD: begin
              if (tgt_bad) begin
                res_status_d = STATUS_BAD;
                state_d      = ST_DONE;
              end else begin
                state_d = ST_GATE;
              end
            end
            OP_CNOT: begin
              if (tgt_bad || ctl_bad) begin
                res_status_d = STATUS_BAD;
                state_d      = ST_DONE;
              end else begin
                state_d = ST_GATE;
              end
            end
            OP_PROB: begin
              if (idx_bad) begin
                res_status_d = STATUS_BAD;
                state_d      = ST_DONE;
              end else begin
                state_d = ST_PROB;
              end
            end
            default: begin
              clr_cnt_d   = '0;
              clr_reply_d = 1'b1;
              state_d     = ST_CLEAR;
            end
          endcase
        end
      end
      ST_GATE: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          if (pair_cnt_q == last_pair) begin
            state_d = ST_DRAIN;
          end else begin
            pair_cnt_d = pair_cnt_q + AW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!bf_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_PROB: begin
        if (prob_done) begin
          res_prob_d = prob_val;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      qubits_q    <= QUBITS_RESET;
      pair_cnt_q  <= '0;
      clr_cnt_q   <= '0;
      phase_q     <= 1'b0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pair_cnt_q  <= pair_cnt_d;
      clr_cnt_q   <= clr_cnt_d;
      phase_q     <= phase_d;
      clr_reply_q <= clr_reply_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        qubits_q <= cfg_qubits_in_use_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tgt_q        <= tgt_d;
    ctl_q        <= ctl_d;
    res_status_q <= res_status_d;
    res_prob_q   <= res_prob_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_prob_q   <= res_prob_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign probability_o = out_prob_q;

endmodule

`default_nettype wire

>>> src/svge_checker.sv
// ----------------------------------------------------------------------------
// svge_checker
// Port-level checks of the state vector gate engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svge_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        status_o,
  input logic [svge_pkg::PROB_W-1:0] probability_o
);

  import svge_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(probability_o))
    else $error("Stalled result beat changed or dropped.");

  a_error_no_prob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_BAD) |-> probability_o == '0)
    else $error("Rejected request reported a nonzero probability.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("A second beat was taken while one is still in work.");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("A result appeared while the engine was idle.");

endmodule

bind state_vector_gate_engine svge_checker u_svge_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the state vector gate engine. A clocked driver
// sends Hadamard, CNOT, probability and ground-state beats from a queue, a
// clocked monitor compares every result beat with the prediction of an
// in-bench amplitude model, and the qubit count is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import svge_pkg::*;

  localparam int     MAX_Q          = 10;
  localparam int     AMP_W          = 18;
  localparam int     DIM_MAX        = 1 << MAX_Q;
  localparam int     PROB_SHIFT     = 2 * (AMP_W - 2) - COEF_FRAC;
  localparam longint AMP_HI         = (longint'(1) <<< (AMP_W - 1)) - 1;
  localparam longint AMP_LO         = -(longint'(1) <<< (AMP_W - 1));
  localparam longint PROB_MAX       = (longint'(1) <<< PROB_W) - 1;
  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     HOLD_CYCLES    = 400;

  typedef logic signed [AMP_W-1:0] amp_t;

  typedef struct {
    svge_op_e          op;
    logic [QSEL_W-1:0] target;
    logic [QSEL_W-1:0] control;
    logic [IDX_W-1:0]  index;
  } gate_req_t;

  typedef struct {
    logic              status;
    logic [PROB_W-1:0] prob;
  } gate_rsp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [QSEL_W-1:0]   cfg_qubits_in_use_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     op_i;
  logic [QSEL_W-1:0]   target_bit_i;
  logic [QSEL_W-1:0]   control_bit_i;
  logic [IDX_W-1:0]    basis_index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                status_o;
  logic [PROB_W-1:0]   probability_o;

  amp_t              amp_re_q [DIM_MAX];
  amp_t              amp_im_q [DIM_MAX];
  logic [QSEL_W-1:0] qubits_cfg;

  gate_req_t pending_ops[$];
  gate_rsp_t awaited_results[$];
  gate_req_t cur_req;
  bit        quiet;
  int        mismatches;
  int        results_seen;
  int        hold_left;
  int        idle_cycles;

  state_vector_gate_engine #(
    .MAX_QUBITS(MAX_Q),
    .AMP_BITS  (AMP_W)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_qubits_in_use_i(cfg_qubits_in_use_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .target_bit_i       (target_bit_i),
    .control_bit_i      (control_bit_i),
    .basis_index_i      (basis_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .probability_o      (probability_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned active_qubits(logic [QSEL_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_Q) return MAX_Q;
    return int'(v);
  endfunction

  function automatic void clear_vector();
    for (int i = 0; i < DIM_MAX; i++) begin
      amp_re_q[i] = '0;
      amp_im_q[i] = '0;
    end
    amp_re_q[0] = amp_t'(longint'(1) <<< (AMP_W - 2));
  endfunction

  function automatic amp_t scale_round(longint sum);
    longint k;
    longint p;
    k = INV_SQRT2_Q30;
    p = (sum * k + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (p > AMP_HI) p = AMP_HI;
    if (p < AMP_LO) p = AMP_LO;
    return amp_t'(p);
  endfunction

  function automatic logic [PROB_W-1:0] square_mag(int unsigned idx);
    longint re;
    longint im;
    longint s;
    re = amp_re_q[idx];
    im = amp_im_q[idx];
    s = re * re + im * im;
    s = (s + (longint'(1) <<< (PROB_SHIFT - 1))) >>> PROB_SHIFT;
    if (s > PROB_MAX) s = PROB_MAX;
    return s[PROB_W-1:0];
  endfunction

  function automatic gate_rsp_t apply_op(gate_req_t r);
    gate_rsp_t   rsp;
    int unsigned n;
    int unsigned dim;
    int unsigned tm;
    int unsigned cm;
    int unsigned j;
    amp_t        ar;
    amp_t        ai;
    amp_t        br;
    amp_t        bi;
    n = active_qubits(qubits_cfg);
    dim = 1 << n;
    rsp.status = STATUS_OK;
    rsp.prob = '0;
    case (r.op)
      OP_HADAMARD: begin
        if (r.target >= n) begin
          rsp.status = STATUS_BAD;
        end else begin
          tm = 1 << r.target;
          for (int unsigned i = 0; i < dim; i++) begin
            if ((i & tm) == 0) begin
              j = i | tm;
              ar = amp_re_q[i];
              ai = amp_im_q[i];
              br = amp_re_q[j];
              bi = amp_im_q[j];
              amp_re_q[i] = scale_round(longint'(ar) + longint'(br));
              amp_im_q[i] = scale_round(longint'(ai) + longint'(bi));
              amp_re_q[j] = scale_round(longint'(ar) - longint'(br));
              amp_im_q[j] = scale_round(longint'(ai) - longint'(bi));
            end
          end
        end
      end
      OP_CNOT: begin
        if (r.control >= n || r.target >= n || r.control == r.target) begin
          rsp.status = STATUS_BAD;
        end else begin
          cm = 1 << r.control;
          tm = 1 << r.target;
          for (int unsigned i = 0; i < dim; i++) begin
            if ((i & cm) != 0 && (i & tm) == 0) begin
              j = i | tm;
              ar = amp_re_q[i];
              ai = amp_im_q[i];
              amp_re_q[i] = amp_re_q[j];
              amp_im_q[i] = amp_im_q[j];
              amp_re_q[j] = ar;
              amp_im_q[j] = ai;
            end
          end
        end
      end
      OP_PROB: begin
        if (r.index >= dim) rsp.status = STATUS_BAD;
        else rsp.prob = square_mag(r.index);
      end
      default: begin
        clear_vector();
      end
    endcase
    return rsp;
  endfunction

  function automatic gate_req_t make_req(svge_op_e op, int t, int c, int idx);
    gate_req_t r;
    r.op = op;
    r.target = QSEL_W'(t);
    r.control = QSEL_W'(c);
    r.index = IDX_W'(idx);
    return r;
  endfunction

  // Mostly well-formed gates and reads on the active register, some noise.
  function automatic gate_req_t rand_req(int unsigned n);
    gate_req_t r;
    int        w;
    w = $urandom_range(99);
    if (w < 35) r.op = OP_HADAMARD;
    else if (w < 60) r.op = OP_CNOT;
    else if (w < 90) r.op = OP_PROB;
    else r.op = OP_GROUND;
    r.target = QSEL_W'($urandom_range(15));
    r.control = QSEL_W'($urandom_range(15));
    r.index = IDX_W'($urandom_range(DIM_MAX - 1));
    if ($urandom_range(9) < 8) begin
      r.target = QSEL_W'($urandom_range(n - 1));
      if (n > 1) r.control = QSEL_W'((r.target + 1 + $urandom_range(n - 2)) % n);
      r.index = IDX_W'($urandom_range((1 << n) - 1));
    end
    return r;
  endfunction

  task automatic write_qubits(logic [QSEL_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_qubits_in_use_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    qubits_cfg = v;
  endtask

  // Sampling at the falling edge sees the settled queues and handshakes.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || awaited_results.size() != 0);
  endtask

  task automatic run_phase(logic [QSEL_W-1:0] v, int count, bit no_idle);
    write_qubits(v);
    quiet = no_idle;
    repeat (count) pending_ops.push_back(rand_req(active_qubits(v)));
    drain();
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) awaited_results.push_back(apply_op(cur_req));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() != 0 && (quiet || $urandom_range(99) >= 30)) begin
          cur_req = pending_ops.pop_front();
          op_i <= cur_req.op;
          target_bit_i <= cur_req.target;
          control_bit_i <= cur_req.control;
          basis_index_i <= cur_req.index;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    gate_rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (results_seen == 100) hold_left = HOLD_CYCLES;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual status %0d probability %0d",
                   $time, status_o, probability_o);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_o);
            mismatches++;
          end
          if (probability_o !== want.prob) begin
            $display("%0t: probability mismatch, expected %0d, actual %0d",
                     $time, want.prob, probability_o);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_qubits_in_use_i <= '0;
    in_valid_i <= 1'b0;
    op_i <= '0;
    target_bit_i <= '0;
    control_bit_i <= '0;
    basis_index_i <= '0;
    out_stall_i <= 1'b0;
    quiet = 1'b0;
    mismatches = 0;
    results_seen = 0;
    hold_left = 0;
    qubits_cfg = QUBITS_RESET;
    clear_vector();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_qubits(4'd10);
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 0));
    pending_ops.push_back(make_req(OP_PROB, 15, 15, 1023));
    pending_ops.push_back(make_req(OP_HADAMARD, 0, 15, 1023));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 0));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 1));
    pending_ops.push_back(make_req(OP_HADAMARD, 9, 0, 0));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 512));
    pending_ops.push_back(make_req(OP_HADAMARD, 10, 0, 0));
    pending_ops.push_back(make_req(OP_HADAMARD, 15, 0, 0));
    pending_ops.push_back(make_req(OP_CNOT, 9, 0, 0));
    pending_ops.push_back(make_req(OP_CNOT, 0, 9, 0));
    pending_ops.push_back(make_req(OP_CNOT, 3, 3, 0));
    pending_ops.push_back(make_req(OP_CNOT, 0, 10, 0));
    pending_ops.push_back(make_req(OP_CNOT, 15, 0, 0));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 513));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 1023));
    pending_ops.push_back(make_req(OP_HADAMARD, 0, 0, 0));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 0));
    pending_ops.push_back(make_req(OP_GROUND, 0, 0, 0));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 0));
    pending_ops.push_back(make_req(OP_HADAMARD, 0, 0, 0));
    pending_ops.push_back(make_req(OP_CNOT, 1, 0, 0));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 3));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 1));
    drain();

    write_qubits(4'd1);
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 2));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 1023));
    pending_ops.push_back(make_req(OP_HADAMARD, 1, 0, 0));
    pending_ops.push_back(make_req(OP_CNOT, 1, 0, 0));
    pending_ops.push_back(make_req(OP_HADAMARD, 0, 0, 0));
    pending_ops.push_back(make_req(OP_PROB, 0, 0, 1));
    drain();

    run_phase(4'd1, 50, 1'b0);
    run_phase(4'd3, 200, 1'b0);
    run_phase(4'd0, 40, 1'b0);
    run_phase(4'd15, 30, 1'b0);
    run_phase(4'd5, 120, 1'b1);
    run_phase(4'd2, 80, 1'b0);
    run_phase(4'd10, 30, 1'b0);

    repeat (64) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
